>>> rtl/core/gcbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbs_pkg: shared types and constants for the ghost cell boundary source
// Codes for faces, boundary kinds and fill actions, the configuration bundle
// and the entry format of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package gcbs_pkg;

  // Grid extent limit; strides above it saturate
  localparam logic [8:0] MAX_EXTENT = 9'd256;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_GRID_SIZE_X    = 3'd0;
  localparam logic [2:0] REG_GRID_SIZE_Y    = 3'd1;
  localparam logic [2:0] REG_FIRST_ACTIVE_X = 3'd2;
  localparam logic [2:0] REG_FIRST_ACTIVE_Y = 3'd3;
  localparam logic [2:0] REG_FIRST_ACTIVE_Z = 3'd4;
  localparam logic [2:0] REG_LAST_ACTIVE_X  = 3'd5;
  localparam logic [2:0] REG_LAST_ACTIVE_Y  = 3'd6;
  localparam logic [2:0] REG_LAST_ACTIVE_Z  = 3'd7;

  // Boundary kinds
  localparam logic [2:0] KIND_REFLECT  = 3'd0;
  localparam logic [2:0] KIND_OUTFLOW  = 3'd1;
  localparam logic [2:0] KIND_INFLOW   = 3'd2;
  localparam logic [2:0] KIND_PERIODIC = 3'd3;
  localparam logic [2:0] KIND_UNDEF    = 3'd4;

  // Face codes; bit 0 marks the high face, bits 2:1 give the axis
  localparam logic [2:0] FACE_X_LOW  = 3'd0;
  localparam logic [2:0] FACE_X_HIGH = 3'd1;
  localparam logic [2:0] FACE_Y_LOW  = 3'd2;
  localparam logic [2:0] FACE_Y_HIGH = 3'd3;
  localparam logic [2:0] FACE_Z_LOW  = 3'd4;
  localparam logic [2:0] FACE_Z_HIGH = 3'd5;

  // Field kinds
  localparam logic [1:0] FIELD_SCALAR = 2'd0;
  localparam logic [1:0] FIELD_VEL_X  = 2'd1;
  localparam logic [1:0] FIELD_VEL_Y  = 2'd2;
  localparam logic [1:0] FIELD_VEL_Z  = 2'd3;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Fill actions
  localparam logic [1:0] ACT_LEAVE    = 2'd0;
  localparam logic [1:0] ACT_COPY     = 2'd1;
  localparam logic [1:0] ACT_COPY_NEG = 2'd2;
  localparam logic [1:0] ACT_INFLOW   = 2'd3;

  // Configuration bundle seen by the datapath
  typedef struct packed {
    logic [2:0][7:0] first_active;  // indexed by axis
    logic [2:0][7:0] last_active;   // indexed by axis
    logic [8:0]      stride_x;      // saturated grid_size_x
    logic [16:0]     stride_xy;     // stride_x * saturated grid_size_y
  } cfg_t;

  // One classified transaction waiting for address arithmetic
  typedef struct packed {
    logic [7:0]        tgt_x;
    logic [7:0]        tgt_y;
    logic [7:0]        tgt_z;
    logic signed [9:0] src_x;   // mirrored coordinates may go negative
    logic signed [9:0] src_y;
    logic signed [9:0] src_z;
    logic [1:0]        action;
    logic [31:0]       fill;
    logic              bad;
  } qent_t;

endpackage

>>> rtl/core/gcbs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbs_regs: configuration register file
// APB-style write/read of the grid geometry, plus the saturated strides and
// the registered plane stride used by the address arithmetic.
// ----------------------------------------------------------------------------
module gcbs_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gcbs_pkg::cfg_t      cfg
);

  logic [8:0]      grid_size_x_r;
  logic [8:0]      grid_size_y_r;
  logic [2:0][7:0] first_active_r;
  logic [2:0][7:0] last_active_r;
  logic [16:0]     stride_xy_r;
  logic [16:0]     stride_xy_nxt;
  logic [8:0]      stride_x;
  logic [8:0]      stride_y;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_x_r  <= 9'd1;
      grid_size_y_r  <= 9'd1;
      first_active_r <= '0;
      last_active_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        gcbs_pkg::REG_GRID_SIZE_X:    grid_size_x_r     <= pwdata[8:0];
        gcbs_pkg::REG_GRID_SIZE_Y:    grid_size_y_r     <= pwdata[8:0];
        gcbs_pkg::REG_FIRST_ACTIVE_X: first_active_r[0] <= pwdata[7:0];
        gcbs_pkg::REG_FIRST_ACTIVE_Y: first_active_r[1] <= pwdata[7:0];
        gcbs_pkg::REG_FIRST_ACTIVE_Z: first_active_r[2] <= pwdata[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_X:  last_active_r[0]  <= pwdata[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_Y:  last_active_r[1]  <= pwdata[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_Z:  last_active_r[2]  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      gcbs_pkg::REG_GRID_SIZE_X:    prdata = {23'd0, grid_size_x_r};
      gcbs_pkg::REG_GRID_SIZE_Y:    prdata = {23'd0, grid_size_y_r};
      gcbs_pkg::REG_FIRST_ACTIVE_X: prdata = {24'd0, first_active_r[0]};
      gcbs_pkg::REG_FIRST_ACTIVE_Y: prdata = {24'd0, first_active_r[1]};
      gcbs_pkg::REG_FIRST_ACTIVE_Z: prdata = {24'd0, first_active_r[2]};
      gcbs_pkg::REG_LAST_ACTIVE_X:  prdata = {24'd0, last_active_r[0]};
      gcbs_pkg::REG_LAST_ACTIVE_Y:  prdata = {24'd0, last_active_r[1]};
      gcbs_pkg::REG_LAST_ACTIVE_Z:  prdata = {24'd0, last_active_r[2]};
      default: prdata = '0;
    endcase
  end

  // Saturate strides to the grid extent limit
  assign stride_x = (grid_size_x_r > gcbs_pkg::MAX_EXTENT) ? gcbs_pkg::MAX_EXTENT
                                                           : grid_size_x_r;
  assign stride_y = (grid_size_y_r > gcbs_pkg::MAX_EXTENT) ? gcbs_pkg::MAX_EXTENT
                                                           : grid_size_y_r;

  // Plane stride, refreshed every cycle
  assign stride_xy_nxt = {8'd0, stride_x} * {8'd0, stride_y};

  always_ff @(posedge clk) begin
    stride_xy_r <= stride_xy_nxt;
  end

  assign cfg.first_active = first_active_r;
  assign cfg.last_active  = last_active_r;
  assign cfg.stride_x     = stride_x;
  assign cfg.stride_xy    = stride_xy_r;

endmodule

>>> rtl/core/gcbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbs_front: ghost cell classifier
// Decodes face and boundary kind, mirrors or clamps the source coordinate
// along the face axis and picks the fill action for each transaction.
// ----------------------------------------------------------------------------
module gcbs_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_coord_x,
  input  logic [7:0]           in_coord_y,
  input  logic [7:0]           in_coord_z,
  input  logic [2:0]           in_face_id,
  input  logic [2:0]           in_boundary_kind,
  input  logic [31:0]          in_inflow_value,
  input  logic [1:0]           in_field_kind,
  input  gcbs_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output gcbs_pkg::qent_t      q_data
);

  logic              face_ok;
  logic              face_high;
  logic [1:0]        axis;
  logic [7:0]        first_sel;
  logic [7:0]        last_sel;
  logic [7:0]        coord_sel;
  logic signed [9:0] mirror;
  logic signed [9:0] clamp;
  logic signed [9:0] src_axis;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign face_ok   = (in_face_id <= gcbs_pkg::FACE_Z_HIGH);
  assign axis      = in_face_id[2:1];
  assign face_high = in_face_id[0];

  // Select the bounds and coordinate along the face axis
  always_comb begin
    first_sel = cfg.first_active[0];
    last_sel  = cfg.last_active[0];
    coord_sel = in_coord_x;
    unique case (axis)
      gcbs_pkg::AXIS_X: begin
        first_sel = cfg.first_active[0];
        last_sel  = cfg.last_active[0];
        coord_sel = in_coord_x;
      end
      gcbs_pkg::AXIS_Y: begin
        first_sel = cfg.first_active[1];
        last_sel  = cfg.last_active[1];
        coord_sel = in_coord_y;
      end
      gcbs_pkg::AXIS_Z: begin
        first_sel = cfg.first_active[2];
        last_sel  = cfg.last_active[2];
        coord_sel = in_coord_z;
      end
      default: ;
    endcase
  end

  // Mirror across the face (wraps as two's complement) or clamp to the edge
  assign mirror = face_high ? signed'({1'b0, last_sel, 1'b1} - {2'b00, coord_sel})
                            : signed'({1'b0, first_sel, 1'b0} - 10'd1
                                      - {2'b00, coord_sel});
  assign clamp  = face_high ? signed'({2'b00, last_sel}) : signed'({2'b00, first_sel});
  assign src_axis = (in_boundary_kind == gcbs_pkg::KIND_REFLECT) ? mirror : clamp;

  // Classify the transaction
  always_comb begin
    q_data.tgt_x  = in_coord_x;
    q_data.tgt_y  = in_coord_y;
    q_data.tgt_z  = in_coord_z;
    q_data.src_x  = signed'({2'b00, in_coord_x});
    q_data.src_y  = signed'({2'b00, in_coord_y});
    q_data.src_z  = signed'({2'b00, in_coord_z});
    q_data.action = gcbs_pkg::ACT_LEAVE;
    q_data.fill   = '0;
    q_data.bad    = 1'b0;
    if (in_boundary_kind > gcbs_pkg::KIND_UNDEF) begin
      q_data.bad = 1'b1;
    end else if (face_ok && (in_boundary_kind == gcbs_pkg::KIND_REFLECT ||
                             in_boundary_kind == gcbs_pkg::KIND_OUTFLOW)) begin
      unique case (axis)
        gcbs_pkg::AXIS_X: q_data.src_x = src_axis;
        gcbs_pkg::AXIS_Y: q_data.src_y = src_axis;
        gcbs_pkg::AXIS_Z: q_data.src_z = src_axis;
        default: ;
      endcase
      // On a reflecting face, negate the copy for the velocity component normal to it
      if (in_boundary_kind == gcbs_pkg::KIND_REFLECT &&
          in_field_kind == axis + 2'd1) begin
        q_data.action = gcbs_pkg::ACT_COPY_NEG;
      end else begin
        q_data.action = gcbs_pkg::ACT_COPY;
      end
    end else if (face_ok && in_boundary_kind == gcbs_pkg::KIND_INFLOW) begin
      q_data.action = gcbs_pkg::ACT_INFLOW;
      q_data.fill   = in_inflow_value;
    end
  end

endmodule

>>> rtl/core/gcbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbs_queue: short FIFO between classifier and address unit
// Lets the front keep accepting transactions while the back stalls.
// ----------------------------------------------------------------------------
module gcbs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gcbs_pkg::qent_t      push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output gcbs_pkg::qent_t      pop_data
);

  gcbs_pkg::qent_t                 mem_r [gcbs_pkg::QDEPTH];
  logic [gcbs_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [gcbs_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [gcbs_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [gcbs_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [gcbs_pkg::QPTR_W:0]       count_r;
  logic [gcbs_pkg::QPTR_W:0]       count_nxt;

  assign full      = (count_r == (gcbs_pkg::QPTR_W+1)'(gcbs_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (gcbs_pkg::QPTR_W+1)'(gcbs_pkg::QDEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

>>> rtl/core/gcbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbs_back: linear address unit
// Two-stage pipeline: stride multiplies, then the address sums into the
// output register. The pipeline advances whenever the output can move.
// ----------------------------------------------------------------------------
module gcbs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gcbs_pkg::cfg_t       cfg,
  input  logic                 q_not_empty,
  input  gcbs_pkg::qent_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          out_target_address,
  output logic [23:0]          out_source_address,
  output logic [1:0]           out_fill_action,
  output logic [31:0]          out_fill_value,
  output logic                 out_bad_kind
);

  // Stage 1: products
  logic        s1_valid_r;
  logic [7:0]  s1_tx_r;
  logic [23:0] s1_ty_r;
  logic [23:0] s1_tz_r;
  logic [23:0] s1_sx_r;
  logic [23:0] s1_sy_r;
  logic [23:0] s1_sz_r;
  logic [1:0]  s1_action_r;
  logic [31:0] s1_fill_r;
  logic        s1_bad_r;

  // Stage 2: output register
  logic        out_valid_r;
  logic [23:0] out_tgt_r;
  logic [23:0] out_src_r;
  logic [1:0]  out_action_r;
  logic [31:0] out_fill_r;
  logic        out_bad_r;

  logic        s2_load;
  logic        s1_load;
  logic [23:0] stride_x24;
  logic [23:0] stride_xy24;
  logic [23:0] src_addr_nxt;
  logic        is_copy;

  assign s2_load    = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_load    = !s1_valid_r || s2_load;
  assign q_pop      = s1_load && q_not_empty;
  assign stride_x24  = {15'd0, cfg.stride_x};
  assign stride_xy24 = {7'd0, cfg.stride_xy};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= q_not_empty;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Multiply coordinates by strides, modulo 2^24
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_tx_r     <= q_data.tgt_x;
      s1_ty_r     <= {16'd0, q_data.tgt_y} * stride_x24;
      s1_tz_r     <= {16'd0, q_data.tgt_z} * stride_xy24;
      s1_sx_r     <= {{14{q_data.src_x[9]}}, q_data.src_x};
      s1_sy_r     <= {{14{q_data.src_y[9]}}, q_data.src_y} * stride_x24;
      s1_sz_r     <= {{14{q_data.src_z[9]}}, q_data.src_z} * stride_xy24;
      s1_action_r <= q_data.action;
      s1_fill_r   <= q_data.fill;
      s1_bad_r    <= q_data.bad;
    end
  end

  // Sum the address terms; the source is zero unless copying
  assign is_copy      = (s1_action_r == gcbs_pkg::ACT_COPY) ||
                        (s1_action_r == gcbs_pkg::ACT_COPY_NEG);
  assign src_addr_nxt = is_copy ? (s1_sx_r + s1_sy_r + s1_sz_r) : 24'd0;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_tgt_r    <= {16'd0, s1_tx_r} + s1_ty_r + s1_tz_r;
      out_src_r    <= src_addr_nxt;
      out_action_r <= s1_action_r;
      out_fill_r   <= s1_fill_r;
      out_bad_r    <= s1_bad_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target_address = out_tgt_r;
  assign out_source_address = out_src_r;
  assign out_fill_action    = out_action_r;
  assign out_fill_value     = out_fill_r;
  assign out_bad_kind       = out_bad_r;

  // Checks
  a_bad_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_action_r == gcbs_pkg::ACT_LEAVE))
    else $error("bad kind with a fill action");

  a_fill_only_inflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != gcbs_pkg::ACT_INFLOW) |-> (out_fill_r == '0))
    else $error("fill value without inflow action");

  a_src_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r == gcbs_pkg::ACT_LEAVE ||
                     out_action_r == gcbs_pkg::ACT_INFLOW)) |-> (out_src_r == '0))
    else $error("source address without copy action");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("stage 1 transaction did not reach the output");

endmodule

>>> rtl/core/ghost_cell_boundary_source.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghost_cell_boundary_source: ghost zone boundary fill address source
// Turns one ghost cell per transaction into its linear address, the source
// address to copy from and the fill action for its boundary kind.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_ready   coords, face, kind, inflow, field
//  out_     output     out_valid/out_ready addresses, action, fill, bad flag
//  config   input      psel/penable/pready 8 geometry registers at 4*i
//
//  One transaction per cycle sustained while the output is not stalled;
//  each passes the queue, multiply and sum stages into the output register.
//  A four-entry queue lets the input keep accepting while the output stalls;
//  in_ready drops only when that queue is full.
//  rst_n is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module ghost_cell_boundary_source (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_coord_x,
  input  logic [7:0]  in_coord_y,
  input  logic [7:0]  in_coord_z,
  input  logic [2:0]  in_face_id,
  input  logic [2:0]  in_boundary_kind,
  input  logic [31:0] in_inflow_value,
  input  logic [1:0]  in_field_kind,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_target_address,
  output logic [23:0] out_source_address,
  output logic [1:0]  out_fill_action,
  output logic [31:0] out_fill_value,
  output logic        out_bad_kind,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gcbs_pkg::cfg_t  cfg;
  gcbs_pkg::qent_t q_wdata;
  gcbs_pkg::qent_t q_rdata;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_not_empty;

  // Geometry registers
  gcbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classify incoming transactions
  gcbs_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_face_id       (in_face_id),
    .in_boundary_kind (in_boundary_kind),
    .in_inflow_value  (in_inflow_value),
    .in_field_kind    (in_field_kind),
    .cfg              (cfg),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  // Decouple front and back
  gcbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  // Address arithmetic and output register
  gcbs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_not_empty        (q_not_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_address (out_target_address),
    .out_source_address (out_source_address),
    .out_fill_action    (out_fill_action),
    .out_fill_value     (out_fill_value),
    .out_bad_kind       (out_bad_kind)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ghost cell boundary source
// Streams directed and random ghost cells through the block under several
// grid geometries written over the register port. Each cell's expected
// addresses, fill action, fill value and error flag are computed here and
// compared with the results in order. Random gaps on both channels and a
// long output hold-off exercise the handshake and the internal queue.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 100;

  // Geometry presets
  localparam int GEO_MIN    = 0;  // 1x1 grid, all active bounds zero
  localparam int GEO_FULL   = 1;  // 256x256 grid, bounds 0..255
  localparam int GEO_RANDOM = 2;  // grid sizes 1..511, any 8-bit bounds
  localparam int GEO_EDGE   = 3;  // oversized strides, bounds pinned at 255

  typedef struct {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [2:0]  face;
    logic [2:0]  kind;
    logic [31:0] inflow;
    logic [1:0]  fkind;
  } ghost_cell_t;

  typedef struct {
    logic [23:0] tgt;
    logic [23:0] src;
    logic [1:0]  action;
    logic [31:0] value;
    logic        bad;
  } fill_t;

  // --------------------------------------------------------------------------
  // Scoreboard: geometry copy, fill predictor and in-order result check
  // --------------------------------------------------------------------------
  class fill_scoreboard;
    logic [8:0] grid_x;
    logic [8:0] grid_y;
    logic [7:0] first_act [3];
    logic [7:0] last_act [3];
    fill_t      fill_q [$];
    int         errors;

    function new();
      grid_x = 9'd1;
      grid_y = 9'd1;
      for (int a = 0; a < 3; a++) begin
        first_act[a] = '0;
        last_act[a]  = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        gcbs_pkg::REG_GRID_SIZE_X:    grid_x       = val[8:0];
        gcbs_pkg::REG_GRID_SIZE_Y:    grid_y       = val[8:0];
        gcbs_pkg::REG_FIRST_ACTIVE_X: first_act[0] = val[7:0];
        gcbs_pkg::REG_FIRST_ACTIVE_Y: first_act[1] = val[7:0];
        gcbs_pkg::REG_FIRST_ACTIVE_Z: first_act[2] = val[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_X:  last_act[0]  = val[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_Y:  last_act[1]  = val[7:0];
        gcbs_pkg::REG_LAST_ACTIVE_Z:  last_act[2]  = val[7:0];
        default: ;
      endcase
    endfunction

    // Saturate a grid size to the extent limit
    function logic [63:0] stride(logic [8:0] g);
      return (g > gcbs_pkg::MAX_EXTENT) ? 64'(gcbs_pkg::MAX_EXTENT) : 64'(g);
    endfunction

    // Coordinates are 64-bit so mirrored values below zero wrap naturally
    function logic [23:0] cell_address(logic [63:0] x, logic [63:0] y, logic [63:0] z);
      logic [63:0] sx;
      logic [63:0] sy;
      logic [63:0] a;
      sx = stride(grid_x);
      sy = stride(grid_y);
      a  = x + y * sx + z * sx * sy;
      return a[23:0];
    endfunction

    function fill_t predict_fill(ghost_cell_t c);
      fill_t       r;
      logic [63:0] cc [3];
      logic [63:0] s [3];
      int          axis;
      bit          high;
      cc[0] = 64'(c.x);
      cc[1] = 64'(c.y);
      cc[2] = 64'(c.z);
      s = cc;
      r.src = '0;
      r.action = gcbs_pkg::ACT_LEAVE;
      r.value = '0;
      r.bad = 1'b0;
      if (c.kind > gcbs_pkg::KIND_UNDEF) begin
        r.bad = 1'b1;
      end else if (c.face <= gcbs_pkg::FACE_Z_HIGH &&
                   (c.kind == gcbs_pkg::KIND_REFLECT ||
                    c.kind == gcbs_pkg::KIND_OUTFLOW)) begin
        axis = int'(c.face >> 1);
        high = c.face[0];
        if (c.kind == gcbs_pkg::KIND_REFLECT) begin
          // mirror across the face plane
          if (high)
            s[axis] = 64'(last_act[axis]) * 64'd2 + 64'd1 - cc[axis];
          else
            s[axis] = 64'(first_act[axis]) * 64'd2 - 64'd1 - cc[axis];
          r.action = (int'(c.fkind) == axis + 1) ? gcbs_pkg::ACT_COPY_NEG
                                                 : gcbs_pkg::ACT_COPY;
        end else begin
          s[axis] = high ? 64'(last_act[axis]) : 64'(first_act[axis]);
          r.action = gcbs_pkg::ACT_COPY;
        end
        r.src = cell_address(s[0], s[1], s[2]);
      end else if (c.face <= gcbs_pkg::FACE_Z_HIGH &&
                   c.kind == gcbs_pkg::KIND_INFLOW) begin
        r.action = gcbs_pkg::ACT_INFLOW;
        r.value  = c.inflow;
      end
      r.tgt = cell_address(cc[0], cc[1], cc[2]);
      return r;
    endfunction

    function void note_cell(ghost_cell_t c);
      fill_q.push_back(predict_fill(c));
    endfunction

    function void check_fill(fill_t got);
      fill_t want;
      if (fill_q.size() == 0) begin
        $error("result transaction with no expected fill pending");
        errors++;
        return;
      end
      want = fill_q.pop_front();
      if (got.tgt !== want.tgt) begin
        $error("target_address: expected %06h, got %06h", want.tgt, got.tgt);
        errors++;
      end
      if (got.src !== want.src) begin
        $error("source_address: expected %06h, got %06h", want.src, got.src);
        errors++;
      end
      if (got.action !== want.action) begin
        $error("fill_action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("fill_value: expected %08h, got %08h", want.value, got.value);
        errors++;
      end
      if (got.bad !== want.bad) begin
        $error("bad_kind: expected %0b, got %0b", want.bad, got.bad);
        errors++;
      end
    endfunction

    function int pending();
      return fill_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_coord_x = '0;
  logic [7:0]  in_coord_y = '0;
  logic [7:0]  in_coord_z = '0;
  logic [2:0]  in_face_id = '0;
  logic [2:0]  in_boundary_kind = '0;
  logic [31:0] in_inflow_value = '0;
  logic [1:0]  in_field_kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_target_address;
  logic [23:0] out_source_address;
  logic [1:0]  out_fill_action;
  logic [31:0] out_fill_value;
  logic        out_bad_kind;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fill_scoreboard sb;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  ghost_cell_boundary_source i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .in_coord_z         (in_coord_z),
    .in_face_id         (in_face_id),
    .in_boundary_kind   (in_boundary_kind),
    .in_inflow_value    (in_inflow_value),
    .in_field_kind      (in_field_kind),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_address (out_target_address),
    .out_source_address (out_source_address),
    .out_fill_action    (out_fill_action),
    .out_fill_value     (out_fill_value),
    .out_bad_kind       (out_bad_kind),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  // Write all geometry registers from a preset; block must be idle
  task automatic load_geometry(int mode);
    logic [31:0] val [8];
    case (mode)
      GEO_MIN: begin
        val[gcbs_pkg::REG_GRID_SIZE_X] = 32'd1;
        val[gcbs_pkg::REG_GRID_SIZE_Y] = 32'd1;
        for (int a = 0; a < 3; a++) begin
          val[gcbs_pkg::REG_FIRST_ACTIVE_X + a] = 32'd0;
          val[gcbs_pkg::REG_LAST_ACTIVE_X + a]  = 32'd0;
        end
      end
      GEO_FULL: begin
        val[gcbs_pkg::REG_GRID_SIZE_X] = 32'd256;
        val[gcbs_pkg::REG_GRID_SIZE_Y] = 32'd256;
        for (int a = 0; a < 3; a++) begin
          val[gcbs_pkg::REG_FIRST_ACTIVE_X + a] = 32'd0;
          val[gcbs_pkg::REG_LAST_ACTIVE_X + a]  = 32'd255;
        end
      end
      GEO_EDGE: begin
        val[gcbs_pkg::REG_GRID_SIZE_X] = 32'd511;
        val[gcbs_pkg::REG_GRID_SIZE_Y] = 32'($urandom_range(257, 510));
        for (int a = 0; a < 3; a++) begin
          val[gcbs_pkg::REG_FIRST_ACTIVE_X + a] = 32'd255;
          val[gcbs_pkg::REG_LAST_ACTIVE_X + a]  = 32'd255;
        end
      end
      default: begin
        val[gcbs_pkg::REG_GRID_SIZE_X] = 32'($urandom_range(1, 511));
        val[gcbs_pkg::REG_GRID_SIZE_Y] = 32'($urandom_range(1, 511));
        for (int a = 0; a < 3; a++) begin
          val[gcbs_pkg::REG_FIRST_ACTIVE_X + a] = 32'($urandom_range(0, 255));
          val[gcbs_pkg::REG_LAST_ACTIVE_X + a]  = 32'($urandom_range(0, 255));
        end
      end
    endcase
    for (int i = 0; i < 8; i++)
      write_reg(3'(i), val[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one cell and hold it until accepted
  task automatic send_cell(ghost_cell_t c);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_coord_x       <= c.x;
    in_coord_y       <= c.y;
    in_coord_z       <= c.z;
    in_face_id       <= c.face;
    in_boundary_kind <= c.kind;
    in_inflow_value  <= c.inflow;
    in_field_kind    <= c.fkind;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(c);
  endtask

  // Take one result; stall first, or hold off long when asked
  task automatic take_fill();
    int    stall;
    fill_t got;
    if (hold_off_req) begin
      stall = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end else begin
      stall = $urandom_range(0, 4);
    end
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
    got.tgt    = out_target_address;
    got.src    = out_source_address;
    got.action = out_fill_action;
    got.value  = out_fill_value;
    got.bad    = out_bad_kind;
    sb.check_fill(got);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic ghost_cell_t make_cell(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                            logic [2:0] face, logic [2:0] kind,
                                            logic [31:0] inflow, logic [1:0] fkind);
    ghost_cell_t c;
    c.x = x;
    c.y = y;
    c.z = z;
    c.face = face;
    c.kind = kind;
    c.inflow = inflow;
    c.fkind = fkind;
    return c;
  endfunction

  // Mostly real ghost cells just outside a face; the rest is raw noise
  function automatic ghost_cell_t random_cell();
    ghost_cell_t c;
    int          axis;
    logic [7:0]  pos;
    c = make_cell(8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), $urandom, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) < 8) begin
      c.face = 3'($urandom_range(0, 5));
      c.kind = 3'($urandom_range(0, 4));
      axis = int'(c.face >> 1);
      if (c.face[0])
        pos = sb.last_act[axis] + 8'd1 + 8'($urandom_range(0, 3));
      else
        pos = sb.first_act[axis] - 8'd1 - 8'($urandom_range(0, 3));
      case (axis)
        gcbs_pkg::AXIS_X: c.x = pos;
        gcbs_pkg::AXIS_Y: c.y = pos;
        default: c.z = pos;
      endcase
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int mode, bit pressure);
    wait_drained();
    load_geometry(mode);
    if (pressure)
      hold_off_req = 1'b1;
    repeat (ITEMS_PER_PHASE) send_cell(random_cell());
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      forever take_fill();
    join_none

    // Directed cells on the reset geometry: every kind, bad faces, extremes
    send_cell(make_cell(8'd0, 8'd0, 8'd0, gcbs_pkg::FACE_X_LOW, gcbs_pkg::KIND_REFLECT,
                        32'h0, gcbs_pkg::FIELD_SCALAR));
    send_cell(make_cell(8'd255, 8'd255, 8'd255, gcbs_pkg::FACE_Z_HIGH,
                        gcbs_pkg::KIND_REFLECT, 32'hFFFF_FFFF, gcbs_pkg::FIELD_VEL_Z));
    send_cell(make_cell(8'd1, 8'd2, 8'd3, gcbs_pkg::FACE_X_HIGH, gcbs_pkg::KIND_OUTFLOW,
                        32'h5555_5555, gcbs_pkg::FIELD_SCALAR));
    send_cell(make_cell(8'd4, 8'd5, 8'd6, gcbs_pkg::FACE_Y_LOW, gcbs_pkg::KIND_INFLOW,
                        32'h3F80_0000, gcbs_pkg::FIELD_VEL_Y));
    send_cell(make_cell(8'd7, 8'd8, 8'd9, gcbs_pkg::FACE_Y_HIGH, gcbs_pkg::KIND_PERIODIC,
                        32'h1234_5678, gcbs_pkg::FIELD_VEL_X));
    send_cell(make_cell(8'd10, 8'd11, 8'd12, gcbs_pkg::FACE_Z_LOW, gcbs_pkg::KIND_UNDEF,
                        32'hAAAA_AAAA, gcbs_pkg::FIELD_SCALAR));
    send_cell(make_cell(8'd13, 8'd14, 8'd15, gcbs_pkg::FACE_X_LOW, 3'd5,
                        32'hDEAD_BEEF, gcbs_pkg::FIELD_VEL_X));
    send_cell(make_cell(8'd16, 8'd17, 8'd18, 3'd6, gcbs_pkg::KIND_REFLECT,
                        32'h0000_0001, gcbs_pkg::FIELD_SCALAR));
    send_cell(make_cell(8'd19, 8'd20, 8'd21, 3'd7, gcbs_pkg::KIND_INFLOW,
                        32'h8000_0000, gcbs_pkg::FIELD_SCALAR));
    send_cell(make_cell(8'd22, 8'd23, 8'd24, 3'd7, 3'd7, 32'h7FFF_FFFF,
                        gcbs_pkg::FIELD_VEL_Z));
    in_valid <= 1'b0;

    // Oversized strides, bounds at the top: mirror and copy on every face
    wait_drained();
    load_geometry(GEO_EDGE);
    for (int f = 0; f <= int'(gcbs_pkg::FACE_Z_HIGH); f++) begin
      send_cell(make_cell(8'($urandom), 8'($urandom), 8'($urandom), 3'(f),
                          gcbs_pkg::KIND_REFLECT, $urandom, 2'(f / 2 + 1)));
      send_cell(make_cell(8'd0, 8'd255, 8'd0, 3'(f), gcbs_pkg::KIND_OUTFLOW, $urandom,
                          gcbs_pkg::FIELD_SCALAR));
    end
    in_valid <= 1'b0;

    // Random phases over several geometries, two with a long output hold-off
    run_phase(GEO_RANDOM, 1'b0);
    run_phase(GEO_FULL,   1'b1);
    run_phase(GEO_RANDOM, 1'b0);
    run_phase(GEO_EDGE,   1'b0);
    run_phase(GEO_RANDOM, 1'b1);
    run_phase(GEO_MIN,    1'b0);
    run_phase(GEO_RANDOM, 1'b0);

    // Drain, then give stray results a chance to show up
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> ghost_cell_boundary_source.f
rtl/core/gcbs_pkg.sv
rtl/core/gcbs_regs.sv
rtl/core/gcbs_front.sv
rtl/core/gcbs_queue.sv
rtl/core/gcbs_back.sv
rtl/core/ghost_cell_boundary_source.sv
dv/tb.sv
